>>> hw/rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers, clocked on a rising edge and
// disabled while the active-low reset is asserted.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check an implication on every rising edge outside reset.
`define ASSERT_CLK(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Check that a condition never holds outside reset.
`define ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);

`endif

>>> hw/rtl/dsos_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// dsos_pkg
// Types, constants and the sine table generator of the one-shot tone voice.
// ---------------------------------------------------------------------------
package dsos_pkg;

  localparam int PHASE_BITS     = 32;
  localparam int SINE_MAG_BITS  = 15;
  localparam int VOLUME_BITS    = 15;
  localparam int ENV_BITS       = 24;
  localparam int DURATION_BITS  = 24;
  localparam int CFG_INDEX_BITS = 2;
  localparam int CFG_DATA_BITS  = 32;
  localparam int PROD1_BITS     = SINE_MAG_BITS + VOLUME_BITS;
  localparam int PROD2_BITS     = PROD1_BITS + ENV_BITS;

  // pi/2 in Q2.30
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam logic [ENV_BITS-1:0] ENV_FULL = '1;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    CFG_PHASE_STEP = 2'd0,
    CFG_VOLUME     = 2'd1,
    CFG_DURATION   = 2'd2,
    CFG_ENV_DEC    = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    logic accept;    // input transfer this cycle
    logic lookup;    // address sine table, advance voice state
    logic mul;       // sine times volume
    logic load_out;  // scale by envelope into output register
  } dsos_cmd_t;

  typedef struct packed {
    logic out_busy;  // output register full and not drained this cycle
  } dsos_status_t;

  // Quarter-wave entry q: Taylor series to x^15 in Q2.30, rounded to Q1.15.
  // Only evaluated at elaboration.
  function automatic logic [SINE_MAG_BITS-1:0] sine_rom_entry(
      input int unsigned q, input int unsigned index_bits);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] sum;
    logic [63:0] rnd;
    x    = ((64'(q) * 64'd2 + 64'd1) * HALF_PI_Q30) >> (index_bits + 1);
    x2   = (x * x) >> 30;
    term = x;
    sum  = x;
    for (int k = 1; k <= 7; k++) begin
      term = (term * x2) >> 30;
      case (k)
        1:       term = term / 64'd6;
        2:       term = term / 64'd20;
        3:       term = term / 64'd42;
        4:       term = term / 64'd72;
        5:       term = term / 64'd110;
        6:       term = term / 64'd156;
        default: term = term / 64'd210;
      endcase
      if ((k % 2) == 1) begin
        sum = sum - term;
      end else begin
        sum = sum + term;
      end
    end
    rnd = (sum * 64'd32767 + (64'd1 << 29)) >> 30;
    return rnd[SINE_MAG_BITS-1:0];
  endfunction

endpackage

>>> hw/rtl/dsos_if.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// dsos_if
// Valid/ready channels of the tone voice: sample tick in, stereo sample out.
// ---------------------------------------------------------------------------
interface dsos_in_if;
  logic valid;
  logic ready;
  logic restart;

  modport source (output valid, output restart, input ready);
  modport sink (input valid, input restart, output ready);
endinterface

interface dsos_out_if #(
  parameter int SAMPLE_BITS = 16
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] left_sample;
  logic signed [SAMPLE_BITS-1:0] right_sample;
  logic                          sounding;

  modport source (output valid, output left_sample, output right_sample,
                  output sounding, input ready);
  modport sink (input valid, input left_sample, input right_sample,
                input sounding, output ready);
endinterface

>>> hw/rtl/dsos_sine_rom.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// dsos_sine_rom
// Quarter-wave sine magnitude table, Q1.15, with registered read.
// ---------------------------------------------------------------------------
module dsos_sine_rom #(
  parameter int SINE_INDEX_BITS = 10
) (
  input  logic                               clk_i,
  input  logic [SINE_INDEX_BITS-1:0]         addr_i,
  output logic [dsos_pkg::SINE_MAG_BITS-1:0] data_o
);

  localparam int Depth = 2 ** SINE_INDEX_BITS;

  logic [dsos_pkg::SINE_MAG_BITS-1:0] rom_tbl [Depth];
  logic [dsos_pkg::SINE_MAG_BITS-1:0] data_q;

  for (genvar g = 0; g < Depth; g++) begin : g_entry
    localparam logic [dsos_pkg::SINE_MAG_BITS-1:0] Entry =
        dsos_pkg::sine_rom_entry(g, SINE_INDEX_BITS);
    assign rom_tbl[g] = Entry;
  end

  always_ff @(posedge clk_i) begin
    data_q <= rom_tbl[addr_i];
  end

  assign data_o = data_q;

endmodule

>>> hw/rtl/dsos_ctrl.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// dsos_ctrl
// Sequencer: accept a tick, look up, multiply, load the output register.
// ---------------------------------------------------------------------------
module dsos_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  dsos_pkg::dsos_status_t status_i,
  output dsos_pkg::dsos_cmd_t    cmd_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOK,
    ST_MUL,
    ST_LOAD
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_LOOK;
        end
      end
      ST_LOOK: state_d = ST_MUL;
      ST_MUL:  state_d = ST_LOAD;
      ST_LOAD: begin
        if (!status_i.out_busy) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o      = (state_q == ST_IDLE);
  assign cmd_o.accept    = (state_q == ST_IDLE) && in_valid_i;
  assign cmd_o.lookup    = (state_q == ST_LOOK);
  assign cmd_o.mul       = (state_q == ST_MUL);
  assign cmd_o.load_out  = (state_q == ST_LOAD) && !status_i.out_busy;

endmodule

>>> hw/rtl/dsos_datapath.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// dsos_datapath
// Voice state, configuration registers, sine lookup, two multiply steps
// and the output register.
// ---------------------------------------------------------------------------
module dsos_datapath #(
  parameter int SINE_INDEX_BITS = 10,
  parameter int SAMPLE_BITS     = 16,
  parameter int COUNT_BITS      = 24
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [dsos_pkg::CFG_INDEX_BITS-1:0] cfg_index_i,
  input  logic [dsos_pkg::CFG_DATA_BITS-1:0]  cfg_data_i,
  input  dsos_pkg::dsos_cmd_t                 cmd_i,
  input  logic                                restart_i,
  output dsos_pkg::dsos_status_t              status_o,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [SAMPLE_BITS-1:0]       sample_o,
  output logic                                sounding_o
);

  localparam int PhaseBits = dsos_pkg::PHASE_BITS;
  localparam int EnvBits   = dsos_pkg::ENV_BITS;
  localparam int DurBits   = dsos_pkg::DURATION_BITS;
  localparam int CmpBits   = (COUNT_BITS > DurBits) ? COUNT_BITS : DurBits;
  localparam int Shift     = dsos_pkg::PROD2_BITS + 1 - SAMPLE_BITS;
  localparam int MagBits   = SAMPLE_BITS - 1;

  // configuration
  logic [PhaseBits-1:0]              phase_step_q;
  logic [dsos_pkg::VOLUME_BITS-1:0]  volume_q;
  logic [DurBits-1:0]                duration_q;
  logic [EnvBits-1:0]                env_dec_q;

  // voice state
  logic                  active_q, active_d;
  logic [COUNT_BITS-1:0] count_q, count_d;
  logic [PhaseBits-1:0]  phase_q, phase_d;
  logic [EnvBits-1:0]    env_q, env_d;

  // per-sample operands
  logic                             sound_q;
  logic                             neg_q;
  logic [EnvBits-1:0]               env_op_q;
  logic [dsos_pkg::PROD1_BITS-1:0]  prod1_q;

  // output register
  logic                          out_valid_q, out_valid_d;
  logic signed [SAMPLE_BITS-1:0] sample_q;
  logic                          sounding_q;

  logic                               sound;
  logic [COUNT_BITS-1:0]              count_inc;
  logic [COUNT_BITS-1:0]              count_next;
  logic [EnvBits-1:0]                 env_next;
  logic [SINE_INDEX_BITS-1:0]         rom_addr;
  logic [dsos_pkg::SINE_MAG_BITS-1:0] rom_data;
  logic [dsos_pkg::PROD2_BITS-1:0]    prod2;
  logic [MagBits-1:0]                 mag;
  logic [SAMPLE_BITS-1:0]             sample_mag;
  logic signed [SAMPLE_BITS-1:0]      sample_val;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_step_q <= '0;
      volume_q     <= '0;
      duration_q   <= '0;
      env_dec_q    <= '0;
    end else if (cfg_we_i) begin
      case (dsos_pkg::cfg_reg_e'(cfg_index_i))
        dsos_pkg::CFG_PHASE_STEP: phase_step_q <= cfg_data_i[PhaseBits-1:0];
        dsos_pkg::CFG_VOLUME:     volume_q     <= cfg_data_i[dsos_pkg::VOLUME_BITS-1:0];
        dsos_pkg::CFG_DURATION:   duration_q   <= cfg_data_i[DurBits-1:0];
        dsos_pkg::CFG_ENV_DEC:    env_dec_q    <= cfg_data_i[EnvBits-1:0];
        default: ;
      endcase
    end
  end

  // sounding test, then advance and retire the voice
  assign sound      = active_q && (CmpBits'(count_q) < CmpBits'(duration_q));
  assign count_inc  = count_q + COUNT_BITS'(1);
  assign count_next = sound ? count_inc : count_q;
  assign env_next   = (env_q > env_dec_q) ? (env_q - env_dec_q) : '0;

  always_comb begin
    active_d = active_q;
    count_d  = count_q;
    phase_d  = phase_q;
    env_d    = env_q;
    if (cmd_i.accept && restart_i) begin
      active_d = 1'b1;
      count_d  = '0;
      phase_d  = '0;
      env_d    = dsos_pkg::ENV_FULL;
    end else if (cmd_i.lookup) begin
      if (sound) begin
        phase_d = phase_q + phase_step_q;
        env_d   = env_next;
        count_d = count_inc;
      end
      active_d = active_q && (CmpBits'(count_next) < CmpBits'(duration_q));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      count_q  <= '0;
      phase_q  <= '0;
      env_q    <= '0;
    end else begin
      active_q <= active_d;
      count_q  <= count_d;
      phase_q  <= phase_d;
      env_q    <= env_d;
    end
  end

  // mirror the index in quadrants 1 and 3
  assign rom_addr = phase_q[PhaseBits-1-2 -: SINE_INDEX_BITS]
                  ^ {SINE_INDEX_BITS{phase_q[PhaseBits-2]}};

  dsos_sine_rom #(
    .SINE_INDEX_BITS(SINE_INDEX_BITS)
  ) u_rom (
    .clk_i (clk_i),
    .addr_i(rom_addr),
    .data_o(rom_data)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.lookup) begin
      sound_q  <= sound;
      neg_q    <= phase_q[PhaseBits-1];
      env_op_q <= env_q;
    end
    if (cmd_i.mul) begin
      prod1_q <= rom_data * volume_q;
    end
  end

  assign prod2      = prod1_q * env_op_q;
  assign mag        = prod2[dsos_pkg::PROD2_BITS-1:Shift];
  assign sample_mag = {1'b0, mag};
  assign sample_val = !sound_q ? '0
                    : (neg_q ? $signed(-sample_mag) : $signed(sample_mag));

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_i.load_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      sample_q   <= sample_val;
      sounding_q <= sound_q;
    end
  end

  assign status_o.out_busy = out_valid_q && !out_ready_i;
  assign out_valid_o       = out_valid_q;
  assign sample_o          = sample_q;
  assign sounding_o        = sounding_q;

endmodule

>>> hw/rtl/decaying_sine_one_shot_top.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// decaying_sine_one_shot_top
// One-shot decaying sine voice: one stereo sample per sample tick.
// ---------------------------------------------------------------------------
// Channel   Dir  Handshake    Payload
// in_if     in   valid/ready  restart
// out_if    out  valid/ready  left_sample, right_sample, sounding
// cfg       in   cfg_we_i     cfg_index_i, cfg_data_i (write only)
//
// A tick passes through accept, sine table read, sine times volume, and
// times envelope into the output register. The two dependent multiplies
// and the registered table read set these steps.
// The output register holds one finished sample; the next tick is taken
// while it waits. A full, undrained output register holds the sequencer
// in its last step. Reset silences the voice and zeroes the configuration.
`include "assert_macros.svh"

module decaying_sine_one_shot_top #(
  parameter int SINE_INDEX_BITS = 10,
  parameter int SAMPLE_BITS     = 16,
  parameter int COUNT_BITS      = 24
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  dsos_in_if.sink                             in_if,
  dsos_out_if.source                          out_if,
  input  logic                                cfg_we_i,
  input  logic [dsos_pkg::CFG_INDEX_BITS-1:0] cfg_index_i,
  input  logic [dsos_pkg::CFG_DATA_BITS-1:0]  cfg_data_i
);

  dsos_pkg::dsos_cmd_t    cmd;
  dsos_pkg::dsos_status_t status;
  logic                          out_valid;
  logic signed [SAMPLE_BITS-1:0] sample;
  logic                          sounding;

  // Sequencer: walks one tick through the datapath.
  dsos_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_if.valid),
    .in_ready_o(in_if.ready),
    .status_i  (status),
    .cmd_o     (cmd)
  );

  // Datapath: voice state, sine table, multiplies, output register.
  dsos_datapath #(
    .SINE_INDEX_BITS(SINE_INDEX_BITS),
    .SAMPLE_BITS    (SAMPLE_BITS),
    .COUNT_BITS     (COUNT_BITS)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .cmd_i      (cmd),
    .restart_i  (in_if.restart),
    .status_o   (status),
    .out_valid_o(out_valid),
    .out_ready_i(out_if.ready),
    .sample_o   (sample),
    .sounding_o (sounding)
  );

  // Both channels carry the same sample.
  assign out_if.valid        = out_valid;
  assign out_if.left_sample  = sample;
  assign out_if.right_sample = sample;
  assign out_if.sounding     = sounding;

  // A transfer in starts the table lookup on the next cycle.
  `ASSERT_CLK(a_accept_then_lookup, clk_i, rst_ni,
              (in_if.valid && in_if.ready) |=> cmd.lookup,
              "tick transfer not followed by lookup")
  // No new tick while one is in flight.
  `ASSERT_NEVER(a_no_accept_in_flight, clk_i, rst_ni,
                (cmd.lookup || cmd.mul) && in_if.ready,
                "input ready during tick processing")
  // Never overwrite an output sample that is still waiting.
  `ASSERT_NEVER(a_no_overwrite, clk_i, rst_ni,
                cmd.load_out && out_if.valid && !out_if.ready,
                "output register overwritten before transfer")
  // Silent samples are zero.
  `ASSERT_CLK(a_silence_zero, clk_i, rst_ni,
              (out_if.valid && !out_if.sounding) |-> (out_if.left_sample == '0),
              "silent sample is not zero")

endmodule

>>> tb/sv/tb_decaying_sine_one_shot_top.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_decaying_sine_one_shot_top
// Self-checking bench for the one-shot decaying sine voice. A scoreboard
// class tracks the voice state and predicts every stereo sample. Plain
// tasks push sample ticks and register writes, with random gaps on the
// tick side and random stalls on the sample side.
// ---------------------------------------------------------------------------
module tb_decaying_sine_one_shot_top;
  import dsos_pkg::*;

  localparam int SINE_IDX_BITS = 10;
  localparam int SAMPLE_W      = 16;
  localparam int COUNT_W       = 24;

  // pi/2 in Q2.30, the span of one quarter wave
  localparam logic [63:0] QUARTER_TURN_Q30 = 64'd1686629713;

  localparam int unsigned CYCLE_LIMIT   = 400000;
  localparam int          RANDOM_TICKS  = 1000;
  localparam int          SETTLE_CYCLES = 12;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] left;
    logic signed [SAMPLE_W-1:0] right;
    logic                       sounding;
  } stereo_sample_t;

  // Voice tracker: mirrors the registers and the voice state, and keeps
  // the samples still owed by the block, oldest first.
  class tone_tracker;
    logic [31:0]        step;
    logic [14:0]        vol;
    logic [23:0]        dur;
    logic [23:0]        dec;
    bit                 live;
    logic [COUNT_W-1:0] count;
    logic [31:0]        phase;
    logic [23:0]        env;
    stereo_sample_t     pending_samples[$];
    int                 errors;

    function new();
      step   = '0;
      vol    = '0;
      dur    = '0;
      dec    = '0;
      live   = 1'b0;
      count  = '0;
      phase  = '0;
      env    = '0;
      errors = 0;
    endfunction

    // Keep only the bits that each register holds.
    function void set_reg(cfg_reg_e idx, logic [31:0] data);
      case (idx)
        CFG_PHASE_STEP: step = data;
        CFG_VOLUME:     vol  = data[14:0];
        CFG_DURATION:   dur  = data[23:0];
        CFG_ENV_DEC:    dec  = data[23:0];
        default: ;
      endcase
    endfunction

    // Quarter-wave magnitude at the middle of bin q: Taylor series up to
    // x^15 in Q2.30, each term truncated, rounded to Q1.15.
    function logic [14:0] quarter_sine(logic [SINE_IDX_BITS-1:0] q);
      logic [63:0] ang;
      logic [63:0] ang_sq;
      logic [63:0] term;
      logic [63:0] acc;
      ang    = ((64'(q) * 64'd2 + 64'd1) * QUARTER_TURN_Q30) / (64'd2 << SINE_IDX_BITS);
      ang_sq = (ang * ang) >> 30;
      term   = ang;
      acc    = ang;
      for (int k = 1; k <= 7; k++) begin
        term = (term * ang_sq) >> 30;
        term = term / (64'(2 * k) * 64'(2 * k + 1));
        if ((k % 2) == 1) begin
          acc = acc - term;
        end else begin
          acc = acc + term;
        end
      end
      return 15'((acc * 64'd32767 + (64'd1 << 29)) >> 30);
    endfunction

    // Advance the voice by one tick and queue the sample it owes.
    function void take_tick(bit restart);
      logic [1:0]               quad;
      logic [SINE_IDX_BITS-1:0] idx;
      logic [14:0]              mag;
      logic [63:0]              prod;
      stereo_sample_t           s;
      s = '0;
      if (restart) begin
        live  = 1'b1;
        count = '0;
        phase = '0;
        env   = 24'hFF_FFFF;
      end
      if (live && (count < COUNT_W'(dur))) begin
        quad = phase[31:30];
        idx  = phase[29 -: SINE_IDX_BITS];
        if (quad[0]) begin
          idx = ~idx;
        end
        mag  = quarter_sine(idx);
        prod = (64'(mag) * 64'(vol) * 64'(env)) >> (55 - SAMPLE_W);
        s.left     = quad[1] ? -prod[SAMPLE_W-1:0] : prod[SAMPLE_W-1:0];
        s.right    = s.left;
        s.sounding = 1'b1;
        phase = phase + step;
        env   = (env > dec) ? (env - dec) : 24'd0;
        count = count + 1'b1;
      end
      if (live && (count >= COUNT_W'(dur))) begin
        live = 1'b0;
      end
      pending_samples.push_back(s);
    endfunction

    function int pending();
      return pending_samples.size();
    endfunction

    // Print one line per mismatch (capped to keep the log short) and count.
    task report(string what);
      if (errors < 200) begin
        $display("MISMATCH: %s", what);
      end
      errors++;
    endtask

    task check_sample(logic signed [SAMPLE_W-1:0] l, logic signed [SAMPLE_W-1:0] r,
                      logic snd);
      stereo_sample_t want;
      if (pending_samples.size() == 0) begin
        report($sformatf("sample with nothing expected: L=%0d R=%0d S=%0b", l, r, snd));
        return;
      end
      want = pending_samples.pop_front();
      if (l !== want.left) begin
        report($sformatf("left_sample got %0d want %0d", l, want.left));
      end
      if (r !== want.right) begin
        report($sformatf("right_sample got %0d want %0d", r, want.right));
      end
      if (snd !== want.sounding) begin
        report($sformatf("sounding got %0b want %0b", snd, want.sounding));
      end
    endtask
  endclass

  logic                      clk_i = 1'b0;
  logic                      rst_ni;
  logic                      cfg_we_i;
  logic [CFG_INDEX_BITS-1:0] cfg_index_i;
  logic [CFG_DATA_BITS-1:0]  cfg_data_i;

  dsos_in_if                          in_ch ();
  dsos_out_if #(.SAMPLE_BITS(SAMPLE_W)) out_ch ();

  tone_tracker tracker;

  // Idle-free stretches: when set, the side moves every item back to back.
  bit          src_calm = 1'b0;
  bit          snk_calm = 1'b0;
  int unsigned cycle_count = 0;

  decaying_sine_one_shot_top #(
    .SINE_INDEX_BITS(SINE_IDX_BITS),
    .SAMPLE_BITS    (SAMPLE_W),
    .COUNT_BITS     (COUNT_W)
  ) uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_if      (in_ch),
    .out_if     (out_ch),
    .cfg_we_i   (cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Abort a hung run.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("decaying_sine_one_shot_top test failed");
      $finish;
    end
  end

  // Check every sample transfer against the oldest prediction. Values seen
  // here are the ones from before the edge, so no race with the drivers.
  always @(posedge clk_i) begin
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      tracker.check_sample(out_ch.left_sample, out_ch.right_sample, out_ch.sounding);
    end
  end

  // Sample sink: per sample, hold ready low for a random stall, then keep
  // it high until the transfer.
  initial begin
    int stall;
    out_ch.ready = 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      stall = snk_calm ? 0 : $urandom_range(0, 7);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk_i);
      while (!out_ch.valid) @(posedge clk_i);
    end
  end

  // Write one register; the write lands on the next edge. Leave the enable
  // high so back-to-back writes need no second assignment in one step.
  task automatic write_reg(cfg_reg_e idx, logic [31:0] data);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    tracker.set_reg(idx, data);
  endtask

  task automatic program_voice(logic [31:0] step_d, logic [31:0] vol_d,
                               logic [31:0] dur_d, logic [31:0] dec_d);
    write_reg(CFG_PHASE_STEP, step_d);
    write_reg(CFG_VOLUME, vol_d);
    write_reg(CFG_DURATION, dur_d);
    write_reg(CFG_ENV_DEC, dec_d);
    cfg_we_i <= 1'b0;
  endtask

  // Send one tick after a random gap; return at the edge of its transfer.
  // Valid stays high so a zero gap on the next tick needs no re-raise.
  task automatic send_tick(bit restart);
    int gap;
    gap = src_calm ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_ch.valid   <= 1'b1;
    in_ch.restart <= restart;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    tracker.take_tick(restart);
  endtask

  // Drop valid after the last tick of a burst, wait for the block to drain, then let it settle.
  task automatic settle();
    in_ch.valid <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  initial begin
    int          done_ticks;
    int          burst;
    int          rate;
    logic [31:0] step_d;
    logic [31:0] vol_d;
    logic [31:0] dur_d;
    logic [31:0] dec_d;

    tracker       = new();
    rst_ni        = 1'b0;
    in_ch.valid   = 1'b0;
    in_ch.restart = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_index_i   = CFG_PHASE_STEP;
    cfg_data_i    = '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset registers: zero duration, so even a restart stays silent.
    send_tick(1'b0);
    send_tick(1'b1);
    settle();

    // Zero duration with full volume; data carries bits above the volume and
    // duration registers' widths, which must be dropped.
    program_voice(32'h4010_0000, 32'hFFFF_FFFF, 32'hFF00_0000, 32'h0000_0000);
    send_tick(1'b1);
    send_tick(1'b0);
    settle();

    // Short tone stepping through all four quadrants, run into silence,
    // then restart while playing.
    program_voice(32'h4010_0000, 32'h0000_7FFF, 32'd6, 32'h0030_0000);
    send_tick(1'b1);
    repeat (7) send_tick(1'b0);
    send_tick(1'b1);
    send_tick(1'b0);
    send_tick(1'b1);
    send_tick(1'b0);
    settle();

    // Envelope underflow on the first step, longest duration, widest step.
    program_voice(32'hFFFF_FFFF, 32'h0000_7FFF, 32'hFFFF_FFFF, 32'h00FF_FFFF);
    send_tick(1'b1);
    send_tick(1'b0);
    send_tick(1'b0);
    settle();

    // Zero volume and zero step: sounding but silent samples.
    program_voice(32'h0000_0000, 32'h0000_0000, 32'd1, 32'd1);
    send_tick(1'b1);
    send_tick(1'b0);
    send_tick(1'b1);
    settle();

    // Random bursts, each under a fresh register setting.
    done_ticks = 0;
    while (done_ticks < RANDOM_TICKS) begin
      case ($urandom_range(0, 3))
        0:       step_d = 32'h0000_0000;
        1:       step_d = 32'hFFFF_FFFF;
        2:       step_d = $urandom();
        default: step_d = $urandom_range(0, 32'h0400_0000);
      endcase
      case ($urandom_range(0, 3))
        0:       vol_d = 32'h0000_0000;
        1:       vol_d = 32'h0000_7FFF;
        2:       vol_d = $urandom();
        default: vol_d = $urandom_range(0, 32767);
      endcase
      case ($urandom_range(0, 7))
        0:       dur_d = 32'h0000_0000;
        1:       dur_d = 32'hFFFF_FFFF;
        2:       dur_d = $urandom_range(1, 400) | ($urandom() & 32'hFF00_0000);
        default: dur_d = $urandom_range(1, 40);
      endcase
      case ($urandom_range(0, 5))
        0:       dec_d = 32'h0000_0000;
        1:       dec_d = 32'h00FF_FFFF;
        2:       dec_d = $urandom();
        default: dec_d = (dur_d[23:0] != 0) ? (32'h0100_0000 / dur_d[23:0])
                                             : $urandom_range(0, 32'h00FF_FFFF);
      endcase
      program_voice(step_d, vol_d, dur_d, dec_d);

      // Pick this burst's idle pattern and how often it retriggers.
      src_calm = ($urandom_range(0, 3) == 0);
      snk_calm = ($urandom_range(0, 3) == 0);
      rate     = $urandom_range(3, 50);
      burst    = $urandom_range(40, 150);
      repeat (burst) begin
        send_tick($urandom_range(1, rate) == 1);
      end
      done_ticks += burst;
      settle();
    end

    if (tracker.pending() != 0) begin
      tracker.report($sformatf("%0d samples never arrived", tracker.pending()));
    end
    if (tracker.errors == 0) begin
      $display("decaying_sine_one_shot_top test passed");
    end else begin
      $display("decaying_sine_one_shot_top test failed");
    end
    $finish;
  end

endmodule
